// ----- rtl/lcgrsa_pkg.sv -----
// lcgrsa_pkg: shared types, constants and helper functions for the skip-ahead LCG.
// Used by lcgrsa_csr, lcgrsa_mac and lcg_random_with_skip_ahead. No dependencies.
package lcgrsa_pkg;

   localparam int SEED_W     = 63;
   localparam int STRIDE_W   = 32;
   localparam int INDEX_W    = 32;
   localparam int TYPE_W     = 2;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 64;

   // generator_type codes
   localparam logic [TYPE_W-1:0] GEN_48     = 2'd1;
   localparam logic [TYPE_W-1:0] GEN_63     = 2'd2;
   localparam logic [TYPE_W-1:0] GEN_63_MIX = 2'd3;

   // register indexes (byte address / 8)
   localparam logic [1:0] REG_TYPE   = 2'd0;
   localparam logic [1:0] REG_STRIDE = 2'd1;
   localparam logic [1:0] REG_SEED   = 2'd2;

   // opcodes
   localparam logic OP_DRAW  = 1'b0;
   localparam logic OP_START = 1'b1;

   localparam logic [SEED_W-1:0] MUL_48     = 63'd19073486328125;
   localparam logic [SEED_W-1:0] MUL_63     = 63'd3512401965023503517;
   localparam logic [SEED_W-1:0] MUL_63_MIX = 63'd9219741426499971445;
   localparam logic [SEED_W-1:0] MASK_48    = {15'd0, {48{1'b1}}};
   localparam logic [SEED_W-1:0] MASK_63    = {SEED_W{1'b1}};

   localparam logic [TYPE_W-1:0]   RST_TYPE   = GEN_48;
   localparam logic [STRIDE_W-1:0] RST_STRIDE = 32'd152917;
   localparam logic [SEED_W-1:0]   RST_SEED   = 63'd1;

   typedef struct packed {
      logic [TYPE_W-1:0]   gen_type;
      logic [STRIDE_W-1:0] stride;
      logic [SEED_W-1:0]   seed;
   } cfg_type;

   typedef struct packed {
      logic              start;
      logic [SEED_W-1:0] a;
      logic [SEED_W-1:0] b;
      logic [SEED_W-1:0] addend;
      logic [SEED_W-1:0] mask;
   } mac_req_type;

   typedef struct packed {
      logic              done;
      logic [SEED_W-1:0] result;
   } mac_rsp_type;

   function automatic logic [SEED_W-1:0] lcg_mult(input logic [TYPE_W-1:0] t);
      case (t)
         GEN_48:  return MUL_48;
         GEN_63:  return MUL_63;
         default: return MUL_63_MIX;
      endcase
   endfunction

   function automatic logic [SEED_W-1:0] lcg_inc(input logic [TYPE_W-1:0] t);
      case (t)
         GEN_63_MIX: return {{(SEED_W-1){1'b0}}, 1'b1};
         default:    return '0;
      endcase
   endfunction

   function automatic logic [SEED_W-1:0] lcg_mask(input logic [TYPE_W-1:0] t);
      case (t)
         GEN_48:  return MASK_48;
         default: return MASK_63;
      endcase
   endfunction

   // seed as Q0.63 fraction
   function automatic logic [SEED_W-1:0] to_frac(input logic [TYPE_W-1:0] t,
                                                 input logic [SEED_W-1:0] s);
      case (t)
         GEN_48:  return {s[47:0], 15'd0};
         default: return s;
      endcase
   endfunction

endpackage

// ----- rtl/lcg_random_with_skip_ahead.sv -----
// lcg_random_with_skip_ahead: top level, LCG with draw and history start (skip-ahead).
// Instantiates lcgrsa_csr and lcgrsa_mac; depends on lcgrsa_pkg.
//
//  channel | direction | handshake            | word
//  req     | in        | req_valid/req_stall  | opcode, history_index
//  rsp     | out       | rsp_valid/rsp_stall  | random_fraction, was_start
//  csr     | in/out    | APB psel/penable     | 64-bit regs at 0x00, 0x08, 0x10
//
// Every product goes through one shared multiply-add unit.
// Draw or sequential start: one product.
// Full jump: two binary exponentiations plus two products; a clear exponent bit
//   costs the c and g products, and a set bit also the g^k and c_k products.
// Reset (synchronous) restores register defaults and clears seeds and history.
// req_stall is high whenever a word is in progress; a finished word waits in the
//   output register while the next request is taken, and rsp stalls hold it there.
module lcg_random_with_skip_ahead (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_opcode,
   input  logic [lcgrsa_pkg::INDEX_W-1:0]      req_history_index,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [lcgrsa_pkg::SEED_W-1:0]       rsp_random_fraction,
   output logic                                rsp_was_start,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [lcgrsa_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [lcgrsa_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [lcgrsa_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                                csr_pready
);

   typedef enum logic [10:0] {
      S_IDLE  = 11'b000_0000_0001,
      S_DRAW  = 11'b000_0000_0010,
      S_SEQ   = 11'b000_0000_0100,
      S_JTEST = 11'b000_0000_1000,
      S_JGK   = 11'b000_0001_0000,
      S_JCK   = 11'b000_0010_0000,
      S_JC    = 11'b000_0100_0000,
      S_JG    = 11'b000_1000_0000,
      S_SKIP  = 11'b001_0000_0000,
      S_FINAL = 11'b010_0000_0000,
      S_EMIT  = 11'b100_0000_0000
   } state_type;

   lcgrsa_pkg::cfg_type     cfg;
   lcgrsa_pkg::mac_req_type mac_req;
   lcgrsa_pkg::mac_rsp_type mac_rsp;

   state_type state_ff, state_in;
   logic      pend_ff, pend_in;
   logic      mul_state, mac_take, seq_hit;

   // generator state
   logic [lcgrsa_pkg::SEED_W-1:0]  cur_ff, cur_in, hseed_ff, hseed_in;
   logic [lcgrsa_pkg::SEED_W-1:0]  smul_ff, smul_in, sinc_ff, sinc_in;
   logic [lcgrsa_pkg::INDEX_W-1:0] pidx_ff, pidx_in;
   logic                           pvalid_ff, pvalid_in;

   // jump working set: remaining exponent, g^(2^i), c_(2^i), accumulated g^k, c_k
   logic [lcgrsa_pkg::SEED_W-1:0]  jk_ff, jk_in, jg_ff, jg_in, jc_ff, jc_in;
   logic [lcgrsa_pkg::SEED_W-1:0]  jgk_ff, jgk_in, jck_ff, jck_in, jg_plus1;
   logic                           jpass_ff, jpass_in;  // 0: stride jump, 1: index jump

   logic [lcgrsa_pkg::INDEX_W-1:0] idx_ff, idx_in;
   logic [lcgrsa_pkg::SEED_W-1:0]  pfrac_ff, pfrac_in, rsp_frac_ff, rsp_frac_in;
   logic                           pstart_ff, pstart_in, rsp_start_ff, rsp_start_in;
   logic                           rsp_valid_ff, rsp_valid_in;

   lcgrsa_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   lcgrsa_mac u_mac (
      .clock (clock),
      .reset (reset),
      .req   (mac_req),
      .rsp   (mac_rsp)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign mac_take  = pend_ff & mac_rsp.done;
   // sequential start: index follows the last one, no wrap past the top
   assign seq_hit   = pvalid_ff &&
                      ({1'b0, pidx_ff} + 33'd1 == {1'b0, req_history_index});
   // (g+1) wraps to zero at 2^63, which is right mod 2^63
   assign jg_plus1  = jg_ff + 63'd1;

   always_comb begin
      state_in     = state_ff;
      pend_in      = pend_ff;
      cur_in       = cur_ff;
      hseed_in     = hseed_ff;
      smul_in      = smul_ff;
      sinc_in      = sinc_ff;
      pidx_in      = pidx_ff;
      pvalid_in    = pvalid_ff;
      jk_in        = jk_ff;
      jg_in        = jg_ff;
      jc_in        = jc_ff;
      jgk_in       = jgk_ff;
      jck_in       = jck_ff;
      jpass_in     = jpass_ff;
      idx_in       = idx_ff;
      pfrac_in     = pfrac_ff;
      pstart_in    = pstart_ff;
      rsp_frac_in  = rsp_frac_ff;
      rsp_start_in = rsp_start_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      mac_req.start  = 1'b0;
      mac_req.a      = '0;
      mac_req.b      = '0;
      mac_req.addend = '0;
      mac_req.mask   = lcgrsa_pkg::lcg_mask(cfg.gen_type);
      mul_state      = 1'b1;

      case (state_ff)
         S_IDLE: begin
            mul_state = 1'b0;
            if (req_valid) begin
               idx_in = req_history_index;
               if (req_opcode == lcgrsa_pkg::OP_DRAW) begin
                  pfrac_in  = lcgrsa_pkg::to_frac(cfg.gen_type, cur_ff);
                  pstart_in = 1'b0;
                  state_in  = S_DRAW;
               end else begin
                  pstart_in = 1'b1;
                  if (seq_hit) begin
                     state_in = S_SEQ;
                  end else begin
                     // stride fits under the smallest modulus, no masking needed
                     jk_in    = {31'd0, cfg.stride};
                     jg_in    = lcgrsa_pkg::lcg_mult(cfg.gen_type);
                     jc_in    = lcgrsa_pkg::lcg_inc(cfg.gen_type);
                     jgk_in   = 63'd1;
                     jck_in   = '0;
                     jpass_in = 1'b0;
                     state_in = S_JTEST;
                  end
               end
            end
         end
         S_DRAW: begin
            mac_req.a      = cur_ff;
            mac_req.b      = lcgrsa_pkg::lcg_mult(cfg.gen_type);
            mac_req.addend = lcgrsa_pkg::lcg_inc(cfg.gen_type);
            if (mac_take) begin
               cur_in   = mac_rsp.result;
               state_in = S_EMIT;
            end
         end
         S_SEQ: begin
            mac_req.a      = smul_ff;
            mac_req.b      = hseed_ff;
            mac_req.addend = sinc_ff;
            if (mac_take) begin
               hseed_in  = mac_rsp.result;
               cur_in    = mac_rsp.result;
               pidx_in   = idx_ff;
               pvalid_in = 1'b1;
               pfrac_in  = lcgrsa_pkg::to_frac(cfg.gen_type, mac_rsp.result);
               state_in  = S_EMIT;
            end
         end
         S_JTEST: begin
            mul_state = 1'b0;
            if (jk_ff == '0) begin
               if (!jpass_ff) begin
                  smul_in  = jgk_ff;
                  sinc_in  = jck_ff;
                  state_in = S_SKIP;
               end else begin
                  state_in = S_FINAL;
               end
            end else if (jk_ff[0]) begin
               state_in = S_JGK;
            end else begin
               state_in = S_JC;
            end
         end
         S_JGK: begin
            mac_req.a = jgk_ff;
            mac_req.b = jg_ff;
            if (mac_take) begin
               jgk_in   = mac_rsp.result;
               state_in = S_JCK;
            end
         end
         S_JCK: begin
            mac_req.a      = jck_ff;
            mac_req.b      = jg_ff;
            mac_req.addend = jc_ff;
            if (mac_take) begin
               jck_in   = mac_rsp.result;
               state_in = S_JC;
            end
         end
         S_JC: begin
            mac_req.a = jg_plus1;
            mac_req.b = jc_ff;
            if (mac_take) begin
               jc_in    = mac_rsp.result;
               state_in = S_JG;
            end
         end
         S_JG: begin
            mac_req.a = jg_ff;
            mac_req.b = jg_ff;
            if (mac_take) begin
               jg_in    = mac_rsp.result;
               jk_in    = jk_ff >> 1;
               state_in = S_JTEST;
            end
         end
         S_SKIP: begin
            // stride*n, reduced by the unit's mask
            mac_req.a = {31'd0, cfg.stride};
            mac_req.b = {31'd0, idx_ff};
            if (mac_take) begin
               jk_in    = mac_rsp.result;
               jg_in    = lcgrsa_pkg::lcg_mult(cfg.gen_type);
               jc_in    = lcgrsa_pkg::lcg_inc(cfg.gen_type);
               jgk_in   = 63'd1;
               jck_in   = '0;
               jpass_in = 1'b1;
               state_in = S_JTEST;
            end
         end
         S_FINAL: begin
            // seed masking comes free: low product bits need only low seed bits
            mac_req.a      = jgk_ff;
            mac_req.b      = cfg.seed;
            mac_req.addend = jck_ff;
            if (mac_take) begin
               hseed_in  = mac_rsp.result;
               cur_in    = mac_rsp.result;
               pidx_in   = idx_ff;
               pvalid_in = 1'b1;
               pfrac_in  = lcgrsa_pkg::to_frac(cfg.gen_type, mac_rsp.result);
               state_in  = S_EMIT;
            end
         end
         S_EMIT: begin
            mul_state = 1'b0;
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_frac_in  = pfrac_ff;
               rsp_start_in = pstart_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            mul_state = 1'b0;
            state_in  = S_IDLE;
         end
      endcase

      // one product per multiply state: issue, then wait for done
      if (mul_state) begin
         mac_req.start = !pend_ff;
         pend_in       = pend_ff ? !mac_rsp.done : 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cur_ff       <= '0;
         hseed_ff     <= '0;
         smul_ff      <= 63'd1;
         sinc_ff      <= '0;
         pidx_ff      <= '0;
         pvalid_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         cur_ff       <= cur_in;
         hseed_ff     <= hseed_in;
         smul_ff      <= smul_in;
         sinc_ff      <= sinc_in;
         pidx_ff      <= pidx_in;
         pvalid_ff    <= pvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      jk_ff        <= jk_in;
      jg_ff        <= jg_in;
      jc_ff        <= jc_in;
      jgk_ff       <= jgk_in;
      jck_ff       <= jck_in;
      jpass_ff     <= jpass_in;
      idx_ff       <= idx_in;
      pfrac_ff     <= pfrac_in;
      pstart_ff    <= pstart_in;
      rsp_frac_ff  <= rsp_frac_in;
      rsp_start_ff <= rsp_start_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_random_fraction = rsp_frac_ff;
   assign rsp_was_start       = rsp_start_ff;

   a_draw_path: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_opcode == lcgrsa_pkg::OP_DRAW)
         |=> state_ff == S_DRAW)
      else $error("draw did not enter draw state");

   a_done_pending: assert property (@(posedge clock) disable iff (reset)
      mac_rsp.done |-> pend_ff)
      else $error("mac result with no product outstanding");

   a_emit_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT && (!rsp_valid_ff || !rsp_stall))
         |=> (rsp_valid_ff && state_ff == S_IDLE))
      else $error("result not loaded into output register");

   a_start_marks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT && pstart_ff) |-> pvalid_ff)
      else $error("history start finished without recording previous index");

   a_stride_then_skip: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_JTEST && jk_ff == '0 && !jpass_ff)
         |=> (state_ff == S_SKIP && smul_ff == $past(jgk_ff)))
      else $error("stride jump not followed by index jump");

endmodule

// ----- rtl/lcgrsa_csr.sv -----
// lcgrsa_csr: APB-style register file for generator type, history stride and initial seed.
// Depends on lcgrsa_pkg.
module lcgrsa_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [lcgrsa_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [lcgrsa_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [lcgrsa_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                                pready,
   output lcgrsa_pkg::cfg_type                 cfg
);

   logic [lcgrsa_pkg::TYPE_W-1:0]   type_ff, type_in;
   logic [lcgrsa_pkg::STRIDE_W-1:0] stride_ff, stride_in;
   logic [lcgrsa_pkg::SEED_W-1:0]   seed_ff, seed_in;
   logic                            wr_en;
   logic [1:0]                      reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite & pready;
   assign reg_idx = paddr[4:3];

   always_comb begin
      type_in   = type_ff;
      stride_in = stride_ff;
      seed_in   = seed_ff;
      if (wr_en) begin
         case (reg_idx)
            lcgrsa_pkg::REG_TYPE: begin
               // zero is not a generator: keep the old type
               if (pwdata[1:0] inside {lcgrsa_pkg::GEN_48, lcgrsa_pkg::GEN_63,
                                       lcgrsa_pkg::GEN_63_MIX}) begin
                  type_in = pwdata[1:0];
               end
            end
            lcgrsa_pkg::REG_STRIDE: stride_in = pwdata[31:0];
            lcgrsa_pkg::REG_SEED:   seed_in   = pwdata[62:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         lcgrsa_pkg::REG_TYPE:   prdata = {62'd0, type_ff};
         lcgrsa_pkg::REG_STRIDE: prdata = {32'd0, stride_ff};
         lcgrsa_pkg::REG_SEED:   prdata = {1'b0, seed_ff};
         default:                prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         type_ff   <= lcgrsa_pkg::RST_TYPE;
         stride_ff <= lcgrsa_pkg::RST_STRIDE;
         seed_ff   <= lcgrsa_pkg::RST_SEED;
      end else begin
         type_ff   <= type_in;
         stride_ff <= stride_in;
         seed_ff   <= seed_in;
      end
   end

   assign cfg.gen_type = type_ff;
   assign cfg.stride   = stride_ff;
   assign cfg.seed     = seed_ff;

endmodule

// ----- rtl/lcgrsa_mac.sv -----
// lcgrsa_mac: shared multiply-add unit, (a*b + addend) & mask on 63-bit operands.
// One 32x32 multiplier, three partial products accumulated in turn. Depends on lcgrsa_pkg.
module lcgrsa_mac (
   input  logic                    clock,
   input  logic                    reset,
   input  lcgrsa_pkg::mac_req_type req,
   output lcgrsa_pkg::mac_rsp_type rsp
);

   logic [lcgrsa_pkg::SEED_W-1:0] a_ff, a_in, b_ff, b_in, mask_ff, mask_in;
   logic [63:0]                   acc_ff, acc_in, prod_ff, prod_in;
   logic [1:0]                    step_ff, step_in;
   logic                          busy_ff, busy_in, done_ff, done_in;
   logic [31:0]                   mul_x, mul_y;

   // low 64 bits of a*b = a0*b0 + ((a1*b0 + a0*b1) << 32)
   always_comb begin
      mul_x   = (step_ff == 2'd1) ? {1'b0, a_ff[62:32]} : a_ff[31:0];
      mul_y   = (step_ff == 2'd2) ? {1'b0, b_ff[62:32]} : b_ff[31:0];
      prod_in = 64'(mul_x) * 64'(mul_y);
   end

   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      mask_in = mask_ff;
      acc_in  = acc_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         a_in    = req.a;
         b_in    = req.b;
         mask_in = req.mask;
         acc_in  = {1'b0, req.addend};
         step_in = 2'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         step_in = step_ff + 2'd1;
         case (step_ff)
            2'd0:    acc_in = acc_ff;
            2'd1:    acc_in = acc_ff + prod_ff;
            default: acc_in = acc_ff + {prod_ff[31:0], 32'd0};
         endcase
         if (step_ff == 2'd3) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= 2'd0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      b_ff    <= b_in;
      mask_ff <= mask_in;
      acc_ff  <= acc_in;
      prod_ff <= prod_in;
   end

   assign rsp.done   = done_ff;
   assign rsp.result = acc_ff[62:0] & mask_ff;

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      req.start |-> (!busy_ff && !done_ff))
      else $error("mac started while busy");

   a_done_single: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("mac done held for more than one cycle");

   a_four_steps: assert property (@(posedge clock) disable iff (reset)
      $rose(busy_ff) |-> ##3 (busy_ff && step_ff == 2'd3))
      else $error("mac step sequence broken");

endmodule

// ----- tb/sv/lcg_random_with_skip_ahead_tb.sv -----
`timescale 1ns / 100ps
// lcg_random_with_skip_ahead_tb: self-checking bench for the skip-ahead LCG block.
// Sends draw and history-start words, predicts each result in-bench and checks it.
// Depends on lcgrsa_pkg and the lcg_random_with_skip_ahead RTL.
module lcg_random_with_skip_ahead_tb;

   // type code that selects no generator; a write of it must leave the type alone
   localparam logic [lcgrsa_pkg::TYPE_W-1:0] GEN_NONE = 2'd0;
   localparam int SETTLE_CYCLES   = 20;   // after the last result, before a register write
   localparam int HOLD_OFF_CYCLES = 400;  // long receiver stall, fills the block
   localparam int PHASES          = 12;
   localparam int WORDS_PER_PHASE = 120;

   typedef struct packed {
      logic [lcgrsa_pkg::SEED_W-1:0] fraction;
      logic                          was_start;
   } lcg_word_type;

   logic                              clock;
   logic                              reset;
   logic                              req_valid;
   logic                              req_stall;
   logic                              req_opcode;
   logic [lcgrsa_pkg::INDEX_W-1:0]    req_history_index;
   logic                              rsp_valid;
   logic                              rsp_stall;
   logic [lcgrsa_pkg::SEED_W-1:0]     rsp_random_fraction;
   logic                              rsp_was_start;
   logic                              csr_psel;
   logic                              csr_penable;
   logic                              csr_pwrite;
   logic [lcgrsa_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [lcgrsa_pkg::CSR_DATA_W-1:0] csr_pwdata;
   logic [lcgrsa_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                              csr_pready;

   lcg_random_with_skip_ahead i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_opcode          (req_opcode),
      .req_history_index   (req_history_index),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_random_fraction (rsp_random_fraction),
      .rsp_was_start       (rsp_was_start),
      .csr_psel            (csr_psel),
      .csr_penable         (csr_penable),
      .csr_pwrite          (csr_pwrite),
      .csr_paddr           (csr_paddr),
      .csr_pwdata          (csr_pwdata),
      .csr_prdata          (csr_prdata),
      .csr_pready          (csr_pready)
   );

   // ---------------------------------------------------------------------------
   // Bench copy of the registers and of the generator state. Arithmetic is done
   // at 64 bits so that every product wraps as the hardware's masked products do.
   // ---------------------------------------------------------------------------
   logic [lcgrsa_pkg::TYPE_W-1:0]   gen_sel;
   logic [lcgrsa_pkg::STRIDE_W-1:0] stride_len;
   logic [lcgrsa_pkg::SEED_W-1:0]   seed_zero;

   logic [63:0]                    live_seed;   // seed that the next draw returns
   logic [63:0]                    hist_seed;   // seed of the last history started
   logic [63:0]                    stride_mul;  // one-stride coefficients, from last full jump
   logic [63:0]                    stride_inc;
   logic [lcgrsa_pkg::INDEX_W-1:0] last_index;
   logic                           have_history;

   lcg_word_type expected_words[$];

   int  mismatches    = 0;
   int  checked_words = 0;
   int  draws         = 0;
   int  seq_starts    = 0;
   int  jump_starts   = 0;
   int  reg_writes    = 0;
   bit  idling_on;
   int  hold_left;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // generous ceiling: every word a worst-case full jump plus stalls, several times over
   initial begin
      #250_000_000;
      $display("timeout: %0d result words still outstanding", expected_words.size());
      $display("TB_ERROR");
      $finish;
   end

   function automatic logic [63:0] step_mul();
      case (gen_sel)
         lcgrsa_pkg::GEN_48: return {1'b0, lcgrsa_pkg::MUL_48};
         lcgrsa_pkg::GEN_63: return {1'b0, lcgrsa_pkg::MUL_63};
         default:            return {1'b0, lcgrsa_pkg::MUL_63_MIX};
      endcase
   endfunction

   function automatic logic [63:0] step_inc();
      return (gen_sel == lcgrsa_pkg::GEN_63_MIX) ? 64'd1 : 64'd0;
   endfunction

   function automatic logic [63:0] seed_mask();
      return (gen_sel == lcgrsa_pkg::GEN_48) ? {1'b0, lcgrsa_pkg::MASK_48}
                                             : {1'b0, lcgrsa_pkg::MASK_63};
   endfunction

   // 48-bit seeds sit at the top of the Q0.63 fraction
   function automatic logic [lcgrsa_pkg::SEED_W-1:0] as_q063(input logic [63:0] s);
      return (gen_sel == lcgrsa_pkg::GEN_48) ? {s[47:0], 15'd0}
                                             : s[lcgrsa_pkg::SEED_W-1:0];
   endfunction

   // coefficients (mul, inc) that advance a seed by skip steps; square-and-multiply
   function automatic void skip_coeffs(input logic [63:0] skip,
                                       output logic [63:0] mul,
                                       output logic [63:0] inc);
      logic [63:0] m, k, g, c;
      m   = seed_mask();
      k   = skip & m;
      g   = step_mul();
      c   = step_inc();
      mul = 64'd1;
      inc = 64'd0;
      while (k != 64'd0) begin
         if (k[0]) begin
            mul = (mul * g) & m;
            inc = (((inc * g) & m) + c) & m;
         end
         c = (((g + 64'd1) & m) * c) & m;
         g = (g * g) & m;
         k = k >> 1;
      end
   endfunction

   // result of one accepted word; updates the bench state as the block does
   function automatic lcg_word_type predict_word(input logic op,
                                                 input logic [lcgrsa_pkg::INDEX_W-1:0] idx);
      lcg_word_type w;
      logic [63:0]  m, jm, jc, skip;
      m = seed_mask();
      if (op == lcgrsa_pkg::OP_DRAW) begin
         w.fraction  = as_q063(live_seed);
         w.was_start = 1'b0;
         live_seed   = (((step_mul() * live_seed) & m) + step_inc()) & m;
         draws++;
         return w;
      end
      // no wrap: index 0 never follows 0xFFFFFFFF
      if (have_history && ({1'b0, last_index} + 33'd1 == {1'b0, idx})) begin
         hist_seed = (((stride_mul * hist_seed) & m) + stride_inc) & m;
         seq_starts++;
      end else begin
         skip_coeffs({32'd0, stride_len}, stride_mul, stride_inc);
         skip = {32'd0, stride_len} * {32'd0, idx};
         skip_coeffs(skip, jm, jc);
         hist_seed = (((jm * ({1'b0, seed_zero} & m)) & m) + jc) & m;
         jump_starts++;
      end
      live_seed    = hist_seed;
      last_index   = idx;
      have_history = 1'b1;
      w.fraction   = as_q063(hist_seed);
      w.was_start  = 1'b1;
      return w;
   endfunction

   task automatic flag_mismatch(input string what, input logic [63:0] got,
                                input logic [63:0] want);
      mismatches++;
      $display("mismatch on result word %0d: %0s got %h expected %h",
               checked_words, what, got, want);
   endtask

   // ---------------------------------------------------------------------------
   // Result side: stall at random (or for a counted hold-off), check each word
   // taken against the oldest expectation.
   // ---------------------------------------------------------------------------
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= idling_on && ($urandom_range(99) < 11);
         end
      end
   end

   always @(posedge clock) begin
      lcg_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_words.size() == 0) begin
            flag_mismatch("unexpected word, fraction", {1'b0, rsp_random_fraction}, 64'd0);
         end else begin
            want = expected_words.pop_front();
            if (rsp_random_fraction !== want.fraction)
               flag_mismatch("random_fraction", {1'b0, rsp_random_fraction},
                             {1'b0, want.fraction});
            if (rsp_was_start !== want.was_start)
               flag_mismatch("was_start", {63'd0, rsp_was_start}, {63'd0, want.was_start});
         end
         checked_words++;
      end
   end

   // ---------------------------------------------------------------------------
   // Request side. A word is offered at a falling edge and held until taken; the
   // prediction is made at the rising edge that takes it.
   // ---------------------------------------------------------------------------
   task automatic send_word(input logic op, input logic [lcgrsa_pkg::INDEX_W-1:0] idx);
      while (idling_on && $urandom_range(99) < 11) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid         <= 1'b1;
      req_opcode        <= op;
      req_history_index <= idx;
      do @(posedge clock); while (req_stall);
      expected_words.push_back(predict_word(op, idx));
   endtask

   // sender stops and waits until every expected word is back, block then idle
   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // APB write: setup then access; only issued with the block idle
   task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
      drain_results();
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 3'b000};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         lcgrsa_pkg::REG_TYPE:
            if (value[1:0] == lcgrsa_pkg::GEN_48 || value[1:0] == lcgrsa_pkg::GEN_63 ||
                value[1:0] == lcgrsa_pkg::GEN_63_MIX)
               gen_sel = value[1:0];
         lcgrsa_pkg::REG_STRIDE: stride_len = value[lcgrsa_pkg::STRIDE_W-1:0];
         default:                seed_zero  = value[lcgrsa_pkg::SEED_W-1:0];
      endcase
      reg_writes++;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // ---------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------

   // reset values: seed 0 draws stay at 0, first start is a full jump,
   // then sequential, backwards, repeated and wrapped indexes
   task automatic test_reset_defaults();
      send_word(lcgrsa_pkg::OP_DRAW, 32'hFFFF_FFFF);
      send_word(lcgrsa_pkg::OP_START, 32'd0);
      send_word(lcgrsa_pkg::OP_DRAW, 32'd0);
      send_word(lcgrsa_pkg::OP_START, 32'd1);
      send_word(lcgrsa_pkg::OP_START, 32'd2);
      send_word(lcgrsa_pkg::OP_START, 32'd7);
      send_word(lcgrsa_pkg::OP_START, 32'd3);
      send_word(lcgrsa_pkg::OP_START, 32'd3);
      send_word(lcgrsa_pkg::OP_START, 32'hFFFF_FFFF);
      send_word(lcgrsa_pkg::OP_START, 32'd0);       // does not follow 0xFFFFFFFF
      send_word(lcgrsa_pkg::OP_DRAW, 32'hA5A5_5A5A);
   endtask

   // each generator, an ignored type code, and a type change between
   // sequential starts (stride coefficients stay from the last full jump)
   task automatic test_generator_types();
      write_reg(lcgrsa_pkg::REG_TYPE, {62'd0, lcgrsa_pkg::GEN_63_MIX});
      send_word(lcgrsa_pkg::OP_START, 32'd0);
      send_word(lcgrsa_pkg::OP_START, 32'd1);
      send_word(lcgrsa_pkg::OP_DRAW, 32'd0);
      write_reg(lcgrsa_pkg::REG_TYPE, {62'd0, lcgrsa_pkg::GEN_63});
      send_word(lcgrsa_pkg::OP_START, 32'd2);
      send_word(lcgrsa_pkg::OP_DRAW, 32'd0);
      write_reg(lcgrsa_pkg::REG_TYPE, {62'd0, GEN_NONE});
      send_word(lcgrsa_pkg::OP_DRAW, 32'd0);
      write_reg(lcgrsa_pkg::REG_TYPE, {62'd0, lcgrsa_pkg::GEN_48});
      send_word(lcgrsa_pkg::OP_START, 32'd3);
      send_word(lcgrsa_pkg::OP_DRAW, 32'd0);
   endtask

   // stride and seed extremes; bit 63 of the seed write is dropped
   task automatic test_register_extremes();
      write_reg(lcgrsa_pkg::REG_STRIDE, 64'd0);
      send_word(lcgrsa_pkg::OP_START, 32'd5);
      send_word(lcgrsa_pkg::OP_START, 32'd6);
      send_word(lcgrsa_pkg::OP_DRAW, 32'd0);
      write_reg(lcgrsa_pkg::REG_STRIDE, 64'hFFFF_FFFF);
      write_reg(lcgrsa_pkg::REG_SEED, 64'hFFFF_FFFF_FFFF_FFFF);
      write_reg(lcgrsa_pkg::REG_TYPE, {62'd0, lcgrsa_pkg::GEN_63_MIX});
      send_word(lcgrsa_pkg::OP_START, 32'hFFFF_FFFF);
      send_word(lcgrsa_pkg::OP_DRAW, 32'd0);
      write_reg(lcgrsa_pkg::REG_SEED, 64'd0);
      write_reg(lcgrsa_pkg::REG_TYPE, {62'd0, lcgrsa_pkg::GEN_63});
      send_word(lcgrsa_pkg::OP_START, 32'd9);
      send_word(lcgrsa_pkg::OP_DRAW, 32'd0);
   endtask

   // mostly runs of draws between sequential starts, with occasional jumps to
   // random, repeated or earlier histories; settings change per phase
   task automatic test_random_histories();
      logic [lcgrsa_pkg::TYPE_W-1:0]  gens[3];
      logic [63:0]                    stride_val;
      logic [63:0]                    seed_val;
      logic [lcgrsa_pkg::INDEX_W-1:0] idx;
      int                             r;
      gens = '{lcgrsa_pkg::GEN_48, lcgrsa_pkg::GEN_63, lcgrsa_pkg::GEN_63_MIX};
      for (int p = 0; p < PHASES; p++) begin
         case (p)
            2:       stride_val = 64'hFFFF_FFFF;
            3:       stride_val = 64'd0;
            8:       stride_val = {32'd0, $urandom};
            default: stride_val = {32'd0, 32'($urandom_range(200000, 1))};
         endcase
         case (p)
            5:       seed_val = 64'd0;
            10:      seed_val = {1'b1, lcgrsa_pkg::MASK_63};
            default: seed_val = {$urandom, $urandom};
         endcase
         write_reg(lcgrsa_pkg::REG_STRIDE, stride_val);
         write_reg(lcgrsa_pkg::REG_SEED, seed_val);
         write_reg(lcgrsa_pkg::REG_TYPE,
                   {62'd0, (p == 6) ? GEN_NONE : gens[$urandom_range(2)]});
         idling_on = (p != 4);   // one phase runs flat out on both sides
         for (int i = 0; i < WORDS_PER_PHASE; i++) begin
            if (p == 7 && i == 10) hold_left = HOLD_OFF_CYCLES;
            if (p == 9 && i == 60) drain_results();
            r = $urandom_range(99);
            if (r < 8) begin
               case ($urandom_range(3))
                  0:       idx = $urandom;
                  1:       idx = $urandom_range(15);
                  2:       idx = '1;
                  default: idx = last_index - 32'($urandom_range(1));
               endcase
               send_word(lcgrsa_pkg::OP_START, idx);
            end else if (r < 30) begin
               send_word(lcgrsa_pkg::OP_START, last_index + 32'd1);
            end else begin
               send_word(lcgrsa_pkg::OP_DRAW, $urandom);
            end
         end
      end
      idling_on = 1'b1;
   endtask

   initial begin
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_opcode        = lcgrsa_pkg::OP_DRAW;
      req_history_index = '0;
      csr_psel          = 1'b0;
      csr_penable       = 1'b0;
      csr_pwrite        = 1'b0;
      csr_paddr         = '0;
      csr_pwdata        = '0;
      idling_on         = 1'b1;
      hold_left         = 0;
      // state after reset
      gen_sel      = lcgrsa_pkg::RST_TYPE;
      stride_len   = lcgrsa_pkg::RST_STRIDE;
      seed_zero    = lcgrsa_pkg::RST_SEED;
      live_seed    = 64'd0;
      hist_seed    = 64'd0;
      stride_mul   = 64'd1;
      stride_inc   = 64'd0;
      last_index   = '0;
      have_history = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_generator_types();
      test_register_extremes();
      test_random_histories();
      drain_results();

      $display("covered: %0d draws, %0d sequential starts, %0d full jumps, %0d register writes",
               draws, seq_starts, jump_starts, reg_writes);
      $display("checked %0d result words, %0d mismatches", checked_words, mismatches);
      if (mismatches == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
